FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// Active unless SYNTH is defined; empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: label");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: label");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/sbr_pkg.sv
// Shared types, constants and command codes of the spectrum bin resampler.
// No dependencies.
package sbr_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int BINS_DEF       = 32;

    localparam int WL_W      = 16;
    localparam int VAL_W     = 32;
    localparam int BIN_W     = 6;
    localparam int STAT_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;
    localparam int ACC_W     = 64;
    localparam int MAW       = 36;
    localparam int DV_W      = 33;

    localparam logic [WL_W-1:0] LOW_RESET  = 16'd5760;
    localparam logic [WL_W-1:0] HIGH_RESET = 16'd13280;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DROP  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    // read address select
    localparam logic [1:0] RD_ZERO  = 2'd0;
    localparam logic [1:0] RD_LAST  = 2'd1;
    localparam logic [1:0] RD_POSM2 = 2'd2;
    localparam logic [1:0] RD_SEG   = 2'd3;

    // write select
    localparam logic [1:0] WR_NONE  = 2'd0;
    localparam logic [1:0] WR_SHIFT = 2'd1;
    localparam logic [1:0] WR_NEW   = 2'd2;

    // multiplier operand select
    localparam logic [1:0] MUL_DV_X = 2'd0;
    localparam logic [1:0] MUL_END0 = 2'd1;
    localparam logic [1:0] MUL_END1 = 2'd2;
    localparam logic [1:0] MUL_G    = 2'd3;

    // divider operand select
    localparam logic DIV_SEG = 1'b0;
    localparam logic DIV_BIN = 1'b1;

    // bin result select
    localparam logic [1:0] RES_ZERO  = 2'd0;
    localparam logic [1:0] RES_FIRST = 2'd1;
    localparam logic [1:0] RES_LAST  = 2'd2;
    localparam logic [1:0] RES_DIV   = 2'd3;

    typedef struct packed {
        logic [WL_W-1:0]         point_wavelength;
        logic signed [VAL_W-1:0] point_value;
        logic                    last_point;
    } in_item_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] bin_value;
        logic [BIN_W-1:0]        bin_number;
        logic                    last_bin;
        logic [STAT_W-1:0]       status;
    } out_item_t;

    typedef struct packed {
        logic       in_load;
        logic [1:0] rd_sel;
        logic [1:0] wr_sel;
        logic       pos_init;
        logic       pos_dec;
        logic       cnt_inc;
        logic       ovf_set;
        logic       run_clear;
        logic       cap_first;
        logic       cap_last;
        logic       bin_init;
        logic       bin_next;
        logic       prev_cap;
        logic       seg_latch;
        logic       j_init;
        logic       j_inc;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       acc_clr;
        logic       acc_add;
        logic       div_start;
        logic       div_sel;
        logic       res_load;
        logic [1:0] res_sel;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic cnt_zero;
        logic last_in;
        logic shift_more;
        logic pos_one;
        logic range_bad;
        logic below;
        logic above;
        logic single;
        logic seg_skip;
        logic j_last;
        logic div_done;
        logic div_busy;
        logic out_free;
        logic bin_last;
    } sts_t;

endpackage

FILE: rtl/spectrum_bin_resampler.sv
// Top level of the spectrum bin resampler: controller plus datapath.
// Depends on sbr_pkg, sbr_ctrl, sbr_dp, assert_macros.svh.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------
//  in       | in_valid / in_stall  | in_data  (sbr_pkg::in_item_t)
//  out      | out_valid / out_stall| out_data (sbr_pkg::out_item_t)
//  cfg      | cfg_write            | cfg_index, cfg_data
//
// Loading a point shifts up each stored entry it moves past; the store has
// one write and one read port. Per bin, a run walks the segments and uses
// the iterative divider once for each segment that overlaps the bin and
// once more for the final mean. Input stalls from acceptance until the
// point is stored or dropped or, for the last point of a set, until the
// last bin of the run sits in the output register; out_stall holds a bin.
// Reset needs no clearing pass: entries are only read below the point count.
`include "assert_macros.svh"

module spectrum_bin_resampler #(
    parameter int MAX_POINTS = sbr_pkg::MAX_POINTS_DEF,
    parameter int BINS       = sbr_pkg::BINS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  sbr_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output sbr_pkg::out_item_t            out_data,
    input  logic                          cfg_write,
    input  logic [sbr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbr_pkg::CFG_W-1:0]     cfg_data
);

    sbr_pkg::cmd_t cmd;
    sbr_pkg::sts_t sts;

    sbr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd     (cmd),
        .sts     (sts)
    );

    sbr_dp #(
        .MAX_POINTS(MAX_POINTS),
        .BINS      (BINS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    `ASSERT_IMPLIES(a_div_idle, clk, rst_n, cmd.div_start, !sts.div_busy)
    `ASSERT_IMPLIES(a_out_free, clk, rst_n, cmd.out_load, sts.out_free)
    `ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && !in_stall, in_stall)
    `ASSERT_IMPLIES(a_clear_on_last, clk, rst_n, cmd.run_clear, sts.bin_last && cmd.out_load)

endmodule

FILE: rtl/sbr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module sbr_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sbr_div.sv
// Iterative floor divider, signed dividend by positive divisor, one bit per cycle.
// No dependencies.
module sbr_div #(
    parameter int NUM_W = 64,
    parameter int DEN_W = 23
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic [DEN_W-1:0]        den,
    output logic                    busy,
    output logic                    done,
    output logic signed [NUM_W-1:0] quo
);

    localparam int SW = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [SW-1:0]    step_reg, step_next;
    logic             neg_reg;
    logic [NUM_W-1:0] mag_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] den_reg;
    logic [NUM_W-1:0] q_reg;

    logic [DEN_W:0]   rem_sh;
    logic             fits;
    logic [DEN_W-1:0] rem_step;
    logic [NUM_W-1:0] quo_step;
    logic [NUM_W-1:0] fin;

    always_comb
    begin
        rem_sh   = {rem_reg, mag_reg[NUM_W-1]};
        fits     = rem_sh >= {1'b0, den_reg};
        rem_step = fits ? DEN_W'(rem_sh - {1'b0, den_reg}) : DEN_W'(rem_sh);
        quo_step = {quo_reg[NUM_W-2:0], fits};
        // floor for negative dividends: -q, or -q-1 when a remainder is left
        if (neg_reg)
        begin
            fin = (rem_step != '0) ? ~quo_step : -quo_step;
        end
        else
        begin
            fin = quo_step;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = SW'(NUM_W);
        end
        else if (busy_reg)
        begin
            step_next = step_reg - SW'(1);
            if (step_reg == SW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= num[NUM_W-1];
            mag_reg <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            rem_reg <= '0;
            quo_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            mag_reg <= {mag_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_step;
            quo_reg <= quo_step;
            if (step_reg == SW'(1))
            begin
                q_reg <= fin;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = $signed(q_reg);

endmodule

FILE: rtl/sbr_dp.sv
// Datapath: point store, bin edges, segment arithmetic, accumulator, output register.
// Depends on sbr_pkg, sbr_ram, sbr_div.
module sbr_dp #(
    parameter int MAX_POINTS = sbr_pkg::MAX_POINTS_DEF,
    parameter int BINS       = sbr_pkg::BINS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  sbr_pkg::cmd_t                   cmd,
    output sbr_pkg::sts_t                   sts,
    input  sbr_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output sbr_pkg::out_item_t              out_data,
    input  logic                            cfg_write,
    input  logic [sbr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sbr_pkg::CFG_W-1:0]       cfg_data
);

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CW    = $clog2(MAX_POINTS + 1);
    localparam int LW    = sbr_pkg::WL_W + $clog2(BINS);
    localparam int MBW   = LW + 1;
    localparam int DENW  = LW + 1;
    localparam int WL_W  = sbr_pkg::WL_W;
    localparam int VAL_W = sbr_pkg::VAL_W;
    localparam int RW    = WL_W + VAL_W;
    localparam int ACC_W = sbr_pkg::ACC_W;
    localparam int MAW   = sbr_pkg::MAW;
    localparam int DV_W  = sbr_pkg::DV_W;
    localparam int BIN_W = sbr_pkg::BIN_W;
    localparam int PW    = MAW + MBW + 1;

    // control state
    logic [WL_W-1:0] low_reg, low_next;
    logic [WL_W-1:0] high_reg, high_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            ovf_reg, ovf_next;
    logic            out_valid_reg, out_valid_next;

    // payload
    sbr_pkg::in_item_t       in_reg;
    logic [AW-1:0]           pos_reg;
    logic [AW-1:0]           j_reg;
    logic [BIN_W-1:0]        k_reg;
    logic [LW-1:0]           l0_reg, l1_reg;
    logic [LW-1:0]           first_l_reg, last_l_reg, prev_l_reg;
    logic signed [VAL_W-1:0] first_v_reg, last_v_reg, prev_v_reg, va_reg;
    logic [MBW-1:0]          x_reg;
    logic [LW-1:0]           es_reg, d_reg;
    logic signed [DV_W-1:0]  dv_reg;
    logic signed [ACC_W-1:0] prod_reg, acc_reg;
    logic signed [VAL_W-1:0] res_reg;
    sbr_pkg::out_item_t      out_reg;

    logic                    ram_we;
    logic [AW-1:0]           ram_raddr;
    logic [RW-1:0]           ram_wdata, ram_rdata;
    logic [WL_W-1:0]         rd_w;
    logic signed [VAL_W-1:0] rd_v;

    logic [WL_W-1:0]         span;
    logic [LW-1:0]           low_l, cur_l, seg_s, seg_e;
    logic signed [MAW-1:0]   mul_a;
    logic [MBW-1:0]          mul_b;
    logic signed [PW-1:0]    mul_p;
    logic signed [ACC_W-1:0] div_num, div_q;
    logic [DENW-1:0]         div_den;
    logic                    div_busy, div_done;
    logic                    range_bad, bin_last;
    logic signed [VAL_W-1:0] sat_q;

    assign rd_w  = ram_rdata[RW-1:VAL_W];
    assign rd_v  = $signed(ram_rdata[VAL_W-1:0]);
    assign span  = high_reg - low_reg;
    assign low_l = LW'(low_reg) * LW'(BINS);
    assign cur_l = LW'(rd_w) * LW'(BINS);
    assign seg_s = (l0_reg > prev_l_reg) ? l0_reg : prev_l_reg;
    assign seg_e = (l1_reg < cur_l) ? l1_reg : cur_l;

    assign range_bad = high_reg <= low_reg;
    assign bin_last  = k_reg == BIN_W'(BINS - 1);

    // point store
    always_comb
    begin
        unique case (cmd.rd_sel)
            sbr_pkg::RD_ZERO:  ram_raddr = '0;
            sbr_pkg::RD_LAST:  ram_raddr = AW'(cnt_reg - CW'(1));
            sbr_pkg::RD_POSM2: ram_raddr = pos_reg - AW'(2);
            sbr_pkg::RD_SEG:   ram_raddr = j_reg;
            default:           ram_raddr = '0;
        endcase
        ram_we    = cmd.wr_sel != sbr_pkg::WR_NONE;
        ram_wdata = (cmd.wr_sel == sbr_pkg::WR_SHIFT) ? ram_rdata
                  : {in_reg.point_wavelength, in_reg.point_value};
    end

    sbr_ram #(
        .WIDTH(RW),
        .DEPTH(MAX_POINTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(pos_reg),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // shared multiplier
    always_comb
    begin
        unique case (cmd.mul_sel)
            sbr_pkg::MUL_DV_X:
            begin
                mul_a = MAW'(dv_reg);
                mul_b = x_reg;
            end
            sbr_pkg::MUL_END0:
            begin
                mul_a = MAW'($signed({first_v_reg, 1'b0}));
                mul_b = (l0_reg < first_l_reg) ? MBW'(first_l_reg - l0_reg) : '0;
            end
            sbr_pkg::MUL_END1:
            begin
                mul_a = MAW'($signed({last_v_reg, 1'b0}));
                mul_b = (l1_reg > last_l_reg) ? MBW'(l1_reg - last_l_reg) : '0;
            end
            sbr_pkg::MUL_G:
            begin
                mul_a = MAW'($signed({va_reg, 1'b0})) + MAW'(div_q);
                mul_b = MBW'(es_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * $signed({1'b0, mul_b});
    end

    // divider operands
    always_comb
    begin
        if (cmd.div_sel == sbr_pkg::DIV_SEG)
        begin
            div_num = $signed({prod_reg[ACC_W-2:0], 1'b0}) + $signed(ACC_W'(d_reg));
            div_den = {d_reg, 1'b0};
        end
        else
        begin
            div_num = acc_reg + $signed(ACC_W'(span));
            div_den = DENW'({span, 1'b0});
        end
    end

    sbr_div #(
        .NUM_W(ACC_W),
        .DEN_W(DENW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.div_start),
        .num  (div_num),
        .den  (div_den),
        .busy (div_busy),
        .done (div_done),
        .quo  (div_q)
    );

    always_comb
    begin
        if ((div_q[ACC_W-1:VAL_W-1] != '0) && (div_q[ACC_W-1:VAL_W-1] != '1))
        begin
            sat_q = div_q[ACC_W-1] ? $signed(sbr_pkg::VAL_MIN) : $signed(sbr_pkg::VAL_MAX);
        end
        else
        begin
            sat_q = div_q[VAL_W-1:0];
        end
    end

    // control registers
    always_comb
    begin
        low_next       = low_reg;
        high_next      = high_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg;
        if (cfg_write)
        begin
            if (cfg_index == sbr_pkg::CFG_LOW)
            begin
                low_next = cfg_data;
            end
            if (cfg_index == sbr_pkg::CFG_HIGH)
            begin
                high_next = cfg_data;
            end
        end
        if (cmd.cnt_inc)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        if (cmd.ovf_set)
        begin
            ovf_next = 1'b1;
        end
        if (cmd.run_clear)
        begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg       <= sbr_pkg::LOW_RESET;
            high_reg      <= sbr_pkg::HIGH_RESET;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            low_reg       <= low_next;
            high_reg      <= high_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            in_reg <= in_data;
        end
        if (cmd.pos_init)
        begin
            pos_reg <= AW'(cnt_reg);
        end
        else if (cmd.pos_dec)
        begin
            pos_reg <= pos_reg - AW'(1);
        end
        if (cmd.cap_first)
        begin
            first_l_reg <= cur_l;
            first_v_reg <= rd_v;
        end
        if (cmd.cap_last)
        begin
            last_l_reg <= cur_l;
            last_v_reg <= rd_v;
        end
        if (cmd.bin_init)
        begin
            k_reg  <= '0;
            l0_reg <= low_l;
            l1_reg <= low_l + LW'(span);
        end
        else if (cmd.bin_next)
        begin
            k_reg  <= k_reg + BIN_W'(1);
            l0_reg <= l1_reg;
            l1_reg <= l1_reg + LW'(span);
        end
        if (cmd.j_init)
        begin
            j_reg <= AW'(1);
        end
        else if (cmd.j_inc)
        begin
            j_reg <= j_reg + AW'(1);
        end
        if (cmd.prev_cap || cmd.seg_latch)
        begin
            prev_l_reg <= cur_l;
            prev_v_reg <= rd_v;
        end
        if (cmd.seg_latch)
        begin
            // s+e-2*la as (s-la)+(e-la)
            x_reg  <= MBW'(seg_s - prev_l_reg) + MBW'(seg_e - prev_l_reg);
            es_reg <= seg_e - seg_s;
            d_reg  <= cur_l - prev_l_reg;
            dv_reg <= DV_W'(rd_v) - DV_W'(prev_v_reg);
            va_reg <= prev_v_reg;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= ACC_W'(mul_p);
        end
        if (cmd.acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + prod_reg;
        end
        if (cmd.res_load)
        begin
            unique case (cmd.res_sel)
                sbr_pkg::RES_ZERO:  res_reg <= '0;
                sbr_pkg::RES_FIRST: res_reg <= first_v_reg;
                sbr_pkg::RES_LAST:  res_reg <= last_v_reg;
                sbr_pkg::RES_DIV:   res_reg <= sat_q;
                default:            res_reg <= '0;
            endcase
        end
        if (cmd.out_load)
        begin
            out_reg.bin_value  <= res_reg;
            out_reg.bin_number <= k_reg;
            out_reg.last_bin   <= bin_last;
            out_reg.status     <= range_bad ? sbr_pkg::STAT_RANGE
                                : ovf_reg ? sbr_pkg::STAT_DROP : sbr_pkg::STAT_OK;
        end
    end

    always_comb
    begin
        sts.full       = cnt_reg == CW'(MAX_POINTS);
        sts.cnt_zero   = cnt_reg == '0;
        sts.last_in    = in_reg.last_point;
        sts.shift_more = rd_w > in_reg.point_wavelength;
        sts.pos_one    = pos_reg == AW'(1);
        sts.range_bad  = range_bad;
        sts.below      = l1_reg <= first_l_reg;
        sts.above      = l0_reg >= last_l_reg;
        sts.single     = cnt_reg == CW'(1);
        sts.seg_skip   = (cur_l <= prev_l_reg) || (seg_e <= seg_s);
        sts.j_last     = CW'(j_reg) == (cnt_reg - CW'(1));
        sts.div_done   = div_done;
        sts.div_busy   = div_busy;
        sts.out_free   = !out_valid_reg || !out_stall;
        sts.bin_last   = bin_last;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

FILE: rtl/sbr_ctrl.sv
// Controller: sequences sorted insertion and the per-bin integration.
// Depends on sbr_pkg.
module sbr_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    output sbr_pkg::cmd_t cmd,
    input  sbr_pkg::sts_t sts
);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_INS     = 5'd1;
    localparam logic [4:0] S_INS_CMP = 5'd2;
    localparam logic [4:0] S_INS_WR  = 5'd3;
    localparam logic [4:0] S_R0      = 5'd4;
    localparam logic [4:0] S_R1      = 5'd5;
    localparam logic [4:0] S_R2      = 5'd6;
    localparam logic [4:0] S_BIN     = 5'd7;
    localparam logic [4:0] S_E0      = 5'd8;
    localparam logic [4:0] S_E1      = 5'd9;
    localparam logic [4:0] S_SP0     = 5'd10;
    localparam logic [4:0] S_SRD     = 5'd11;
    localparam logic [4:0] S_SCHK    = 5'd12;
    localparam logic [4:0] S_SM1     = 5'd13;
    localparam logic [4:0] S_SDV     = 5'd14;
    localparam logic [4:0] S_SDW     = 5'd15;
    localparam logic [4:0] S_SAC     = 5'd16;
    localparam logic [4:0] S_FIN     = 5'd17;
    localparam logic [4:0] S_FW      = 5'd18;
    localparam logic [4:0] S_OUT     = 5'd19;

    logic [4:0] state_reg, state_next;
    logic [4:0] after_ins;

    assign after_ins = sts.last_in ? S_R0 : S_IDLE;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_INS;
                end
            end
            S_INS:
            begin
                if (sts.full)
                begin
                    cmd.ovf_set = 1'b1;
                    state_next  = after_ins;
                end
                else
                begin
                    cmd.pos_init = 1'b1;
                    if (sts.cnt_zero)
                    begin
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        cmd.rd_sel = sbr_pkg::RD_LAST;
                        state_next = S_INS_CMP;
                    end
                end
            end
            S_INS_CMP:
            begin
                if (sts.shift_more)
                begin
                    cmd.wr_sel  = sbr_pkg::WR_SHIFT;
                    cmd.pos_dec = 1'b1;
                    if (sts.pos_one)
                    begin
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        cmd.rd_sel = sbr_pkg::RD_POSM2;
                    end
                end
                else
                begin
                    cmd.wr_sel  = sbr_pkg::WR_NEW;
                    cmd.cnt_inc = 1'b1;
                    state_next  = after_ins;
                end
            end
            S_INS_WR:
            begin
                cmd.wr_sel  = sbr_pkg::WR_NEW;
                cmd.cnt_inc = 1'b1;
                state_next  = after_ins;
            end
            S_R0:
            begin
                cmd.rd_sel = sbr_pkg::RD_ZERO;
                state_next = S_R1;
            end
            S_R1:
            begin
                cmd.rd_sel    = sbr_pkg::RD_LAST;
                cmd.cap_first = 1'b1;
                state_next    = S_R2;
            end
            S_R2:
            begin
                cmd.cap_last = 1'b1;
                cmd.bin_init = 1'b1;
                state_next   = S_BIN;
            end
            S_BIN:
            begin
                priority if (sts.range_bad)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = sbr_pkg::RES_ZERO;
                    state_next   = S_OUT;
                end
                else if (sts.below)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = sbr_pkg::RES_FIRST;
                    state_next   = S_OUT;
                end
                else if (sts.above)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = sbr_pkg::RES_LAST;
                    state_next   = S_OUT;
                end
                else if (sts.single)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = sbr_pkg::RES_FIRST;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.acc_clr = 1'b1;
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = sbr_pkg::MUL_END0;
                    state_next  = S_E0;
                end
            end
            S_E0:
            begin
                cmd.acc_add = 1'b1;
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sbr_pkg::MUL_END1;
                state_next  = S_E1;
            end
            S_E1:
            begin
                cmd.acc_add = 1'b1;
                cmd.rd_sel  = sbr_pkg::RD_ZERO;
                state_next  = S_SP0;
            end
            S_SP0:
            begin
                cmd.prev_cap = 1'b1;
                cmd.j_init   = 1'b1;
                state_next   = S_SRD;
            end
            S_SRD:
            begin
                cmd.rd_sel = sbr_pkg::RD_SEG;
                state_next = S_SCHK;
            end
            S_SCHK:
            begin
                if (sts.seg_skip)
                begin
                    cmd.prev_cap = 1'b1;
                    if (sts.j_last)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        cmd.j_inc  = 1'b1;
                        state_next = S_SRD;
                    end
                end
                else
                begin
                    cmd.seg_latch = 1'b1;
                    state_next    = S_SM1;
                end
            end
            S_SM1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = sbr_pkg::MUL_DV_X;
                state_next  = S_SDV;
            end
            S_SDV:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = sbr_pkg::DIV_SEG;
                state_next    = S_SDW;
            end
            S_SDW:
            begin
                if (sts.div_done)
                begin
                    cmd.mul_en  = 1'b1;
                    cmd.mul_sel = sbr_pkg::MUL_G;
                    state_next  = S_SAC;
                end
            end
            S_SAC:
            begin
                cmd.acc_add = 1'b1;
                if (sts.j_last)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.j_inc  = 1'b1;
                    state_next = S_SRD;
                end
            end
            S_FIN:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = sbr_pkg::DIV_BIN;
                state_next    = S_FW;
            end
            S_FW:
            begin
                cmd.div_sel = sbr_pkg::DIV_BIN;
                if (sts.div_done)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_sel  = sbr_pkg::RES_DIV;
                    state_next   = S_OUT;
                end
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.bin_last)
                    begin
                        cmd.run_clear = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        cmd.bin_next = 1'b1;
                        state_next   = S_BIN;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = state_reg != S_IDLE;

endmodule

FILE: sim/tb.sv
// Self-checking testbench for spectrum_bin_resampler: loads point sets, resamples
// them under several wavelength ranges and checks every bin against a local model.
// Depends on sbr_pkg and the spectrum_bin_resampler RTL.
`timescale 1ns / 100ps

module tb;

    localparam int NBINS     = sbr_pkg::BINS_DEF;
    localparam int CAPACITY  = sbr_pkg::MAX_POINTS_DEF;
    localparam int BNW       = sbr_pkg::BIN_W;
    localparam int CFGW      = sbr_pkg::CFG_W;
    localparam int LIMIT     = 4000000;
    localparam int SETTLE    = 200;

    class bin_scoreboard;
        int unsigned          wl_store[CAPACITY];
        longint               val_store[CAPACITY];
        int unsigned          count;
        bit                   dropped;
        int unsigned          wl_low;
        int unsigned          wl_high;
        sbr_pkg::out_item_t   expected_bins[$];
        int                   errors;

        function new();
            count   = 0;
            dropped = 0;
            wl_low  = int'(sbr_pkg::LOW_RESET);
            wl_high = int'(sbr_pkg::HIGH_RESET);
            errors  = 0;
        endfunction

        function void set_reg(logic [sbr_pkg::CFG_IDX_W-1:0] idx,
                              logic [sbr_pkg::CFG_W-1:0] data);
            if (idx == sbr_pkg::CFG_LOW)
                wl_low = int'(data);
            else
                wl_high = int'(data);
        endfunction

        function longint floor_quot(longint a, longint d);
            longint q;
            q = a / d;
            if ((a % d) != 0 && a < 0)
                q--;
            return q;
        endfunction

        function longint bin_average(longint l0, longint l1);
            longint first, lastw, sum, la, lb, s, e, d, dv, g;
            int n;
            n = count;
            first = longint'(wl_store[0]) * NBINS;
            lastw = longint'(wl_store[n-1]) * NBINS;
            sum = 0;
            if (l1 <= first)
                return val_store[0];
            if (l0 >= lastw)
                return val_store[n-1];
            if (n == 1)
                return val_store[0];
            if (l0 < first)
                sum += 2 * val_store[0] * (first - l0);
            if (l1 > lastw)
                sum += 2 * val_store[n-1] * (l1 - lastw);
            for (int i = 0; i + 1 < n; i++)
            begin
                la = longint'(wl_store[i]) * NBINS;
                lb = longint'(wl_store[i+1]) * NBINS;
                s = (l0 > la) ? l0 : la;
                e = (l1 < lb) ? l1 : lb;
                d = lb - la;
                if (d <= 0 || e <= s)
                    continue;
                dv = val_store[i+1] - val_store[i];
                g = 2 * val_store[i] + floor_quot(2 * dv * (s + e - 2 * la) + d, 2 * d);
                sum += g * (e - s);
            end
            return floor_quot(sum + (l1 - l0), 2 * (l1 - l0));
        endfunction

        // called for each accepted input transaction
        function void take_point(sbr_pkg::in_item_t p);
            int unsigned        pos;
            longint             span, base, r;
            sbr_pkg::out_item_t b;
            if (count >= CAPACITY)
            begin
                dropped = 1;
            end
            else
            begin
                pos = count;
                while (pos > 0 && wl_store[pos-1] > int'(p.point_wavelength))
                begin
                    wl_store[pos]  = wl_store[pos-1];
                    val_store[pos] = val_store[pos-1];
                    pos--;
                end
                wl_store[pos]  = int'(p.point_wavelength);
                val_store[pos] = longint'(p.point_value);
                count++;
            end
            if (!p.last_point)
                return;
            span = longint'(wl_high) - longint'(wl_low);
            base = longint'(wl_low) * NBINS;
            for (int k = 0; k < NBINS; k++)
            begin
                r = 0;
                if (wl_high <= wl_low)
                begin
                    b.status = sbr_pkg::STAT_RANGE;
                end
                else
                begin
                    r = bin_average(base + span * k, base + span * (k + 1));
                    if (r > 64'sd2147483647)
                        r = 64'sd2147483647;
                    if (r < -64'sd2147483648)
                        r = -64'sd2147483648;
                    b.status = dropped ? sbr_pkg::STAT_DROP : sbr_pkg::STAT_OK;
                end
                b.bin_value  = r[31:0];
                b.bin_number = BNW'(k);
                b.last_bin   = (k == NBINS - 1);
                expected_bins.push_back(b);
            end
            count   = 0;
            dropped = 0;
        endfunction

        // called for each accepted output transaction
        function void check_bin(sbr_pkg::out_item_t got);
            sbr_pkg::out_item_t exp_b;
            if (expected_bins.size() == 0)
            begin
                $error("unexpected bin transaction %0d", got.bin_number);
                errors++;
                return;
            end
            exp_b = expected_bins.pop_front();
            if (got.bin_value !== exp_b.bin_value)
            begin
                $error("bin_value expected %0d actual %0d", exp_b.bin_value, got.bin_value);
                errors++;
            end
            if (got.bin_number !== exp_b.bin_number)
            begin
                $error("bin_number expected %0d actual %0d", exp_b.bin_number,
                       got.bin_number);
                errors++;
            end
            if (got.last_bin !== exp_b.last_bin)
            begin
                $error("last_bin expected %0d actual %0d", exp_b.last_bin, got.last_bin);
                errors++;
            end
            if (got.status !== exp_b.status)
            begin
                $error("status expected %0d actual %0d", exp_b.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    sbr_pkg::in_item_t             in_data;
    logic                          out_valid;
    logic                          out_stall;
    sbr_pkg::out_item_t            out_data;
    logic                          cfg_write;
    logic [sbr_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [sbr_pkg::CFG_W-1:0]     cfg_data;

    bin_scoreboard sb;
    bit            quiet;
    bit            hold_req;
    int            cycles;

    spectrum_bin_resampler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_bin(out_data);
    end

    // receiver: random stall bursts, plus one long hold on request
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (3000) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_point(input logic [15:0] wl, input logic [31:0] val, input bit last);
        sbr_pkg::in_item_t p;
        p.point_wavelength = wl;
        p.point_value      = val;
        p.last_point       = last;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= p;
        do
            @(posedge clk);
        while (in_stall);
        sb.take_point(p);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.expected_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [sbr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sbr_pkg::CFG_W-1:0] data);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        sb.set_reg(idx, data);
    endtask

    task automatic set_range(input int lo, input int hi);
        write_reg(sbr_pkg::CFG_LOW, CFGW'(lo));
        write_reg(sbr_pkg::CFG_HIGH, CFGW'(hi));
    endtask

    function automatic logic [15:0] pick_wl();
        if (sb.wl_high > sb.wl_low && $urandom_range(0, 9) < 7)
            return 16'($urandom_range(sb.wl_low, sb.wl_high));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [31:0] pick_val();
        if ($urandom_range(0, 2) == 0)
            return $urandom();
        return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
    endfunction

    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_point(pick_wl(), pick_val(), i == n - 1);
    endtask

    initial
    begin
        int sent;
        int n;
        sb        = new();
        quiet     = 0;
        hold_req  = 0;
        cycles    = 0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_write = 1'b0;
        cfg_index = sbr_pkg::CFG_LOW;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset range: single point, field extremes, equal wavelengths, unsorted
        send_point(16'd9000, 32'h0001_8000, 1);
        send_point(16'd0, 32'h7FFF_FFFF, 0);
        send_point(16'hFFFF, 32'h8000_0000, 1);
        send_point(16'd9000, 32'h0010_0000, 0);
        send_point(16'd7000, 32'd100, 0);
        send_point(16'd7000, -32'sd500, 0);
        send_point(16'd12000, 32'hFFF0_0000, 0);
        send_point(16'd6000, 32'h0002_0000, 1);
        send_point(16'd13000, 32'h7FFF_FFFF, 0);
        send_point(16'd13100, 32'h7FFF_FFFF, 1);
        // all data below, then above the range
        send_point(16'd100, 32'd7, 0);
        send_point(16'd200, 32'd9, 1);
        send_point(16'd60000, -32'sd3, 0);
        send_point(16'd60001, 32'd4, 1);

        set_range(0, 65535);
        send_point(16'd0, 32'h8000_0000, 0);
        send_point(16'd32768, 32'h7FFF_FFFF, 0);
        send_point(16'd65535, 32'h5555_AAAA, 1);

        set_range(8000, 8000);
        send_point(16'd8000, 32'd1, 0);
        send_point(16'd9000, 32'd2, 1);
        set_range(65535, 0);
        send_point(16'd4000, 32'd5, 1);

        // capacity overflow, final point dropped
        set_range(1000, 40000);
        for (int i = 0; i < CAPACITY + 6; i++)
            send_point(16'($urandom_range(1000, 40000)), pick_val(), i == CAPACITY + 5);

        // receiver holds off while sets keep coming
        hold_req = 1;
        send_set(3);
        send_set(4);
        send_set(2);

        set_range(int'(sbr_pkg::LOW_RESET), int'(sbr_pkg::HIGH_RESET));
        sent = 0;
        while (sent < 50)
        begin
            if (sent >= 35)
                quiet = 1;
            if ($urandom_range(0, 4) == 0)
            begin
                case ($urandom_range(0, 4))
                    0: set_range(0, 65535);
                    1: set_range(int'(sbr_pkg::LOW_RESET), int'(sbr_pkg::HIGH_RESET));
                    2: set_range($urandom_range(0, 65535), $urandom_range(0, 65535));
                    3:
                    begin
                        n = $urandom_range(0, 65535);
                        set_range(n, n);
                    end
                    default:
                    begin
                        n = $urandom_range(0, 60000);
                        set_range(n, n + $urandom_range(1, 5535));
                    end
                endcase
            end
            n = $urandom_range(1, 6);
            send_set(n);
            sent += n;
        end

        wait_idle();
        if (sb.errors == 0 && sb.expected_bins.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
